[design/lr_pkg.sv]
// Line rasterizer package: coordinate widths, transaction structs and the
// line descriptor passed from the setup front end to the stepping back end.
// No dependencies.
package lr_pkg;

	localparam int COORD_BITS = 6;
	localparam int ERR_W      = COORD_BITS + 2;
	localparam int DESC_DEPTH = 2;
	localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
	localparam int DESC_CNT_W = DESC_PTR_W + 1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ERR_W-1:0]      err_t;

	typedef struct packed {
		coord_t      start_x;
		coord_t      start_y;
		coord_t      end_x;
		coord_t      end_y;
		logic [31:0] line_color;
	} line_in_t;

	typedef struct packed {
		coord_t      pixel_x;
		coord_t      pixel_y;
		logic [31:0] pixel_color;
		logic        last_pixel;
	} pixel_out_t;

	// Normalized line: major axis increasing, minor delta as sign and magnitude.
	typedef struct packed {
		logic        steep;
		logic        min_dir;
		coord_t      maj_start;
		coord_t      min_start;
		coord_t      maj_len;
		coord_t      min_len;
		logic [31:0] color;
	} line_desc_t;

	typedef struct packed {
		logic [DESC_CNT_W-1:0] cnt;
		logic                  full;
		logic                  empty;
	} fifo_status_t;

	typedef struct packed {
		logic busy;
	} back_status_t;

endpackage

[design/lr_front.sv]
// Line rasterizer front end: classifies a segment (steep or not), orders the
// endpoints along the major axis and forms the deltas. Uses lr_pkg.
module lr_front import lr_pkg::*; (
	input  line_in_t   seg,
	output line_desc_t desc
);

	coord_t adx, ady;
	coord_t maj_a, maj_b, min_a, min_b;
	coord_t maj_s, maj_e, min_s, min_e;
	logic   steep;

	always_comb begin
		adx   = (seg.start_x > seg.end_x) ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
		ady   = (seg.start_y > seg.end_y) ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
		steep = adx < ady;

		maj_a = steep ? seg.start_y : seg.start_x;
		min_a = steep ? seg.start_x : seg.start_y;
		maj_b = steep ? seg.end_y   : seg.end_x;
		min_b = steep ? seg.end_x   : seg.end_y;

		if (maj_a > maj_b) begin
			maj_s = maj_b;
			min_s = min_b;
			maj_e = maj_a;
			min_e = min_a;
		end else begin
			maj_s = maj_a;
			min_s = min_a;
			maj_e = maj_b;
			min_e = min_b;
		end

		desc.steep     = steep;
		desc.min_dir   = min_e < min_s;
		desc.maj_start = maj_s;
		desc.min_start = min_s;
		desc.maj_len   = maj_e - maj_s;
		desc.min_len   = (min_e < min_s) ? min_s - min_e : min_e - min_s;
		desc.color     = seg.line_color;
	end

endmodule

[design/lr_desc_fifo.sv]
// Line rasterizer descriptor queue: short FIFO between setup and stepping.
// Uses lr_pkg.
module lr_desc_fifo import lr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  line_desc_t   wr_data,
	input  logic         rd,
	output line_desc_t   rd_data,
	output fifo_status_t status
);

	line_desc_t            entry_q [DESC_DEPTH];
	logic [DESC_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [DESC_CNT_W-1:0] cnt_q;
	logic                  do_wr, do_rd;

	assign status.cnt   = cnt_q;
	assign status.full  = cnt_q == DESC_CNT_W'(DESC_DEPTH);
	assign status.empty = cnt_q == '0;
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_data      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/lr_back.sv]
// Line rasterizer back end: steps one pixel per cycle along the major axis
// while the output register is free, with an exact rounding error accumulator,
// into an output register. Uses lr_pkg.
module lr_back import lr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         desc_avail,
	input  line_desc_t   desc,
	output logic         desc_take,
	output pixel_out_t   pixel,
	output logic         pixel_valid,
	input  logic         pixel_pop,
	output back_status_t status
);

	logic        busy_q, out_valid_q;
	logic        steep_q, dir_q;
	coord_t      maj_q, min_q, left_q, dmaj_q, dmin_q;
	err_t        err_q;
	logic [31:0] color_q;
	pixel_out_t  out_q;

	logic         out_free, emit, last;
	logic [ERR_W:0] twod, up, dn, err_ext, step2;

	assign out_free    = !out_valid_q || pixel_pop;
	assign emit        = busy_q && out_free;
	assign last        = left_q == '0;
	assign desc_take   = !busy_q && desc_avail;
	assign pixel       = out_q;
	assign pixel_valid = out_valid_q;
	assign status.busy = busy_q;

	// Remainder stays in [0, 2*dmaj); one correction per step since dmin <= dmaj.
	always_comb begin
		twod    = {2'b00, dmaj_q, 1'b0};
		step2   = {2'b00, dmin_q, 1'b0};
		err_ext = {1'b0, err_q};
		up      = err_ext + step2;
		dn      = err_ext - step2;
	end

	always_ff @(posedge clk) begin
		if (desc_take) begin
			steep_q <= desc.steep;
			dir_q   <= desc.min_dir;
			maj_q   <= desc.maj_start;
			min_q   <= desc.min_start;
			left_q  <= desc.maj_len;
			dmaj_q  <= desc.maj_len;
			dmin_q  <= desc.min_len;
			err_q   <= ERR_W'(desc.maj_len);
			color_q <= desc.color;
		end else if (emit && !last) begin
			maj_q  <= maj_q + 1'b1;
			left_q <= left_q - 1'b1;
			if (!dir_q) begin
				if (up >= twod) begin
					err_q <= ERR_W'(up - twod);
					min_q <= min_q + 1'b1;
				end else begin
					err_q <= ERR_W'(up);
				end
			end else begin
				if (dn[ERR_W]) begin
					err_q <= ERR_W'(dn + twod);
					min_q <= min_q - 1'b1;
				end else begin
					err_q <= ERR_W'(dn);
				end
			end
		end
		if (emit) begin
			out_q.pixel_x     <= steep_q ? min_q : maj_q;
			out_q.pixel_y     <= steep_q ? maj_q : min_q;
			out_q.pixel_color <= color_q;
			out_q.last_pixel  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (desc_take) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pixel_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/line_rasterizer_core.sv]
// Line rasterizer core: top level joining setup front end, descriptor queue
// and pixel stepping back end. Uses lr_pkg, lr_front, lr_desc_fifo, lr_back.
//
// Usage:
//   Input channel (push/full): one transaction is a line segment, two endpoints
//   and a 32-bit color. It is taken on a clock edge with push high, full low.
//   Result channel (empty/pop): one transaction per pixel, x, y, the color
//   unchanged, and last_pixel set on the line's final pixel. Pixels come out in
//   increasing major-axis order; a zero-length line yields one pixel.
//   Path: with the back end idle, a line goes from the queue into the stepper
//   registers, and its first pixel then into the output register.
//   Throughput: one pixel per cycle while pop keeps the output register free;
//   a new line is loaded only after the last pixel; the pixel stepper is the
//   limiting unit. Setup runs ahead and queues up to 2 lines.
//   Reset (arst_n low) empties the queue and the output register and idles the
//   stepper. If pop is held low the stepper stops with the current pixel held
//   on the result ports; the input side keeps taking lines until the queue
//   is full.
module line_rasterizer_core import lr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  line_in_t   segment,
	output logic       empty,
	input  logic       pop,
	output pixel_out_t pixel
);

	line_desc_t   front_desc, queue_desc;
	fifo_status_t fifo_stat;
	back_status_t back_stat;
	logic         desc_take, pixel_valid;

	lr_front u_front (
		.seg  (segment),
		.desc (front_desc)
	);

	lr_desc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_data (front_desc),
		.rd      (desc_take),
		.rd_data (queue_desc),
		.status  (fifo_stat)
	);

	lr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc_avail  (!fifo_stat.empty),
		.desc        (queue_desc),
		.desc_take   (desc_take),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_pop   (pop),
		.status      (back_stat)
	);

	assign full  = fifo_stat.full;
	assign empty = !pixel_valid;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.cnt <= DESC_CNT_W'(DESC_DEPTH))
		else $error("descriptor queue count beyond depth");

	a_mid_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pixel.last_pixel) |-> back_stat.busy)
		else $error("stepper went idle before the last pixel");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!back_stat.busy && fifo_stat.empty && (empty || pop)) |=> empty)
		else $error("pixel appeared with no line in flight");

	a_take_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		desc_take |=> back_stat.busy)
		else $error("line taken from queue but stepper not busy");

endmodule

[tb/sv/testbench.sv]
// Testbench for line_rasterizer_core: sends line segments, predicts every pixel
// with its own integer stepping model and checks each popped pixel in order.
// Depends on lr_pkg and the line_rasterizer_core RTL.
`timescale 1ns / 100ps

module testbench;
	import lr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_LINES = 135;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	line_in_t   segment = '0;
	logic       full;
	logic       empty;
	pixel_out_t pixel;

	pixel_out_t pending_pixels[$];
	int         error_count = 0;
	int         cycle_count = 0;
	bit         calm = 1'b0;    // no idling on either side while set

	line_rasterizer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.segment(segment),
		.empty  (empty),
		.pop    (pop),
		.pixel  (pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[line_rasterizer_core] ERROR");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Expected pixels of one segment: transpose steep lines, order by major axis,
	// minor = floor((2*s*D + 2*M*k + D) / (2*D)), ties rounded upward.
	function automatic void plot_line(input line_in_t seg);
		int ax, ay, bx, by, adx, ady, tmp, dmaj, dmin, num, minor, major;
		bit steep;
		pixel_out_t px;
		ax = seg.start_x;
		ay = seg.start_y;
		bx = seg.end_x;
		by = seg.end_y;
		adx = (ax > bx) ? ax - bx : bx - ax;
		ady = (ay > by) ? ay - by : by - ay;
		steep = (adx < ady);
		if (steep) begin
			tmp = ax; ax = ay; ay = tmp;
			tmp = bx; bx = by; by = tmp;
		end
		if (ax > bx) begin
			tmp = ax; ax = bx; bx = tmp;
			tmp = ay; ay = by; by = tmp;
		end
		dmaj = bx - ax;
		dmin = by - ay;
		for (int k = 0; k <= dmaj; k++) begin
			if (dmaj == 0) begin
				minor = ay;
			end else begin
				num = 2 * ay * dmaj + 2 * dmin * k + dmaj;
				minor = num / (2 * dmaj);
			end
			major = ax + k;
			px.pixel_x = steep ? coord_t'(minor) : coord_t'(major);
			px.pixel_y = steep ? coord_t'(major) : coord_t'(minor);
			px.pixel_color = seg.line_color;
			px.last_pixel = (k == dmaj);
			pending_pixels.push_back(px);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
	end

	always @(posedge clk) begin : check_pixels
		pixel_out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_pixels.size() == 0) begin
				report($sformatf("unexpected pixel (%0d,%0d)", pixel.pixel_x, pixel.pixel_y));
			end else begin
				want = pending_pixels.pop_front();
				if (pixel.pixel_x !== want.pixel_x)
					report($sformatf("pixel_x %0d, want %0d", pixel.pixel_x, want.pixel_x));
				if (pixel.pixel_y !== want.pixel_y)
					report($sformatf("pixel_y %0d, want %0d", pixel.pixel_y, want.pixel_y));
				if (pixel.pixel_color !== want.pixel_color)
					report($sformatf("pixel_color %h, want %h", pixel.pixel_color,
						want.pixel_color));
				if (pixel.last_pixel !== want.last_pixel)
					report($sformatf("last_pixel %b, want %b at (%0d,%0d)", pixel.last_pixel,
						want.last_pixel, want.pixel_x, want.pixel_y));
			end
		end
	end

	// One input transaction; push is left high so back-to-back sends need no gap.
	task automatic send_line(input int sx, input int sy, input int ex, input int ey,
		input logic [31:0] color);
		line_in_t seg;
		seg.start_x = coord_t'(sx);
		seg.start_y = coord_t'(sy);
		seg.end_x = coord_t'(ex);
		seg.end_y = coord_t'(ey);
		seg.line_color = color;
		while (!calm && $urandom_range(0, 99) < 33) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		segment <= seg;
		@(posedge clk);
		while (full)
			@(posedge clk);
		plot_line(seg);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	task automatic send_random_line();
		int sx, sy, ex, ey, len;
		sx = $urandom_range(0, COORD_MAX);
		sy = $urandom_range(0, COORD_MAX);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				ex = $urandom_range(0, COORD_MAX);
				ey = $urandom_range(0, COORD_MAX);
			end
			4, 5: begin
				ex = clamp_coord(sx + $urandom_range(0, 8) - 4);
				ey = clamp_coord(sy + $urandom_range(0, 8) - 4);
			end
			6: begin
				ex = sx;
				ey = sy;
			end
			7: begin
				if ($urandom_range(0, 1)) begin
					ex = $urandom_range(0, COORD_MAX);
					ey = sy;
				end else begin
					ex = sx;
					ey = $urandom_range(0, COORD_MAX);
				end
			end
			8: begin
				len = $urandom_range(0, 20);
				ex = clamp_coord(sx + ($urandom_range(0, 1) ? len : -len));
				ey = clamp_coord(sy + ($urandom_range(0, 1) ? len : -len));
			end
			default: begin
				sx = $urandom_range(0, 1) * COORD_MAX;
				sy = $urandom_range(0, 1) * COORD_MAX;
				ex = $urandom_range(0, 1) * COORD_MAX;
				ey = $urandom_range(0, COORD_MAX);
			end
		endcase
		send_line(sx, sy, ex, ey, $urandom());
	endtask

	task automatic test_extremes();
		send_line(0, 0, 0, 0, 32'h0000_0000);            // zero length
		send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
		send_line(0, 0, COORD_MAX, 0, 32'hFFFF_FFFF);
		send_line(COORD_MAX, COORD_MAX, 0, COORD_MAX, 32'h0000_0000);
		send_line(0, 0, 0, COORD_MAX, 32'hA5A5_5A5A);
		send_line(COORD_MAX, COORD_MAX, COORD_MAX, 0, 32'h5A5A_A5A5);
		send_line(0, 0, COORD_MAX, COORD_MAX, 32'h1234_5678);   // 45 degrees, not steep
		send_line(COORD_MAX, 0, 0, COORD_MAX, 32'h8765_4321);
	endtask

	task automatic test_octants();
		send_line(32, 32, 40, 35, 32'h0102_0304);
		send_line(32, 32, 35, 40, 32'h0506_0708);
		send_line(32, 32, 29, 40, 32'h090A_0B0C);
		send_line(32, 32, 24, 35, 32'h0D0E_0F10);
		send_line(32, 32, 24, 29, 32'h1112_1314);
		send_line(32, 32, 29, 24, 32'h1516_1718);
		send_line(32, 32, 35, 24, 32'h191A_1B1C);
		send_line(32, 32, 40, 29, 32'h1D1E_1F20);
	endtask

	task automatic test_rounding_ties();
		send_line(0, 0, 2, 1, 32'hDEAD_BEEF);    // half step rising
		send_line(0, 1, 2, 0, 32'hCAFE_F00D);    // half step falling
		send_line(10, 10, 14, 11, 32'h0BAD_C0DE);
	endtask

	task automatic test_endpoint_order();
		send_line(3, 50, 47, 9, 32'h00FF_00FF);
		send_line(47, 9, 3, 50, 32'h00FF_00FF);
	endtask

	// Sender holds off until every pixel of the previous line has been popped.
	task automatic test_drain_pause();
		repeat (4) begin
			send_random_line();
			wait_drained();
		end
	endtask

	task automatic test_random();
		for (int n = 0; n < RANDOM_LINES; n++) begin
			calm = (n >= 60 && n < 100);
			send_random_line();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_octants();
		test_rounding_ties();
		test_endpoint_order();
		test_drain_pause();
		test_random();
		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[line_rasterizer_core] OK");
		else
			$display("[line_rasterizer_core] ERROR");
		$finish;
	end

endmodule
